[rtl/core/oipo_pkg.sv]
// Optical ID pattern overlay: shared types and constants.
// Used by the top level and oipo_probe_map; depends on nothing.
package oipo_pkg;

	localparam int unsigned COORD_W = 12;
	localparam int unsigned GEO_W = 14;

	localparam logic [7:0] PKT_HEAD = 8'hA5;
	localparam logic [7:0] PKT_TAIL = 8'hD5;
	localparam logic [7:0] ROW_MARGIN = 8'd20;

	localparam logic [COORD_W-1:0] WIDTH_RESET = 12'd640;
	localparam logic [COORD_W-1:0] HEIGHT_RESET = 12'd448;

	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_PROBE = 1'b1;

	localparam logic [1:0] COLOR_NONE = 2'd0;
	localparam logic [1:0] COLOR_MAGENTA = 2'd1;
	localparam logic [1:0] COLOR_CYAN = 2'd2;
	localparam logic [1:0] COLOR_YELLOW = 2'd3;

	typedef struct packed {
		logic kind;
		logic [7:0] id_char;
		logic first_char;
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
	} cmd_t;

	typedef struct packed {
		logic covered;
		logic [1:0] color_code;
		logic char_dropped;
	} result_t;

	typedef struct packed {
		logic covered;
		logic marker;
		logic use_mem;
		logic [7:0] fix_byte;
		logic [2:0] bit_idx;
	} probe_t;

endpackage

[rtl/core/optical_id_pattern_overlay_unit.sv]
// Optical ID pattern overlay unit: top level with command, result and config ports.
// Depends on oipo_pkg, oipo_id_store and oipo_probe_map.
//
// One command is taken every clock cycle (busy never rises); its result shows on
// result with done high for one cycle, in command order. The depth comes from the
// input register, the registered read of the ID character memory, and the result
// register. A load is visible to a probe that starts in the very next cycle. The
// receiver cannot stall: a result not taken in its done cycle can be overwritten
// by the next one. Write screen_width/screen_height only while idle.
module optical_id_pattern_overlay_unit #(
	parameter int unsigned MAX_ID_CHARS = 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  oipo_pkg::cmd_t               cmd,
	output logic                         done,
	output oipo_pkg::result_t            result,
	input  logic                         cfg_we,
	input  logic                         cfg_idx,
	input  logic [oipo_pkg::COORD_W-1:0] cfg_data
);

	localparam int unsigned LEN_W = $clog2(MAX_ID_CHARS + 1);
	localparam int unsigned PL_W = $clog2(MAX_ID_CHARS + 8);
	localparam int unsigned AW = (MAX_ID_CHARS > 1) ? $clog2(MAX_ID_CHARS) : 1;

	logic [oipo_pkg::COORD_W-1:0] width_q, height_q;
	logic valid_s1, valid_s2, done_q;
	oipo_pkg::cmd_t cmd_s1;
	oipo_pkg::probe_t probe, probe_s2;
	oipo_pkg::result_t result_q;
	logic is_probe_s2, dropped, dropped_s2, load;
	logic [LEN_W-1:0] len;
	logic [7:0] sum, rd_data_s2, pkt_byte;
	logic [AW-1:0] rd_addr;
	logic [1:0] color;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= oipo_pkg::WIDTH_RESET;
			height_q <= oipo_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				oipo_pkg::REG_WIDTH: width_q <= cfg_data;
				oipo_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: width_q <= width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	assign load = valid_s1 && (cmd_s1.kind == oipo_pkg::KIND_LOAD);

	oipo_id_store #(
		.MAX_ID_CHARS(MAX_ID_CHARS),
		.LEN_W(LEN_W),
		.AW(AW)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.id_char(cmd_s1.id_char),
		.first_char(cmd_s1.first_char),
		.rd_addr(rd_addr),
		.len(len),
		.sum(sum),
		.dropped(dropped),
		.rd_data_s2(rd_data_s2)
	);

	oipo_probe_map #(
		.LEN_W(LEN_W),
		.PL_W(PL_W),
		.AW(AW)
	) u_map (
		.screen_width(width_q),
		.screen_height(height_q),
		.pixel_x(cmd_s1.pixel_x),
		.pixel_y(cmd_s1.pixel_y),
		.len(len),
		.sum(sum),
		.probe(probe),
		.rd_addr(rd_addr)
	);

	always_ff @(posedge clk) begin
		probe_s2 <= probe;
		is_probe_s2 <= (cmd_s1.kind == oipo_pkg::KIND_PROBE);
		dropped_s2 <= dropped;
	end

	always_comb begin
		pkt_byte = probe_s2.use_mem ? rd_data_s2 : probe_s2.fix_byte;
		if (!is_probe_s2 || !probe_s2.covered) begin
			color = oipo_pkg::COLOR_NONE;
		end else if (probe_s2.marker) begin
			color = oipo_pkg::COLOR_MAGENTA;
		end else if (pkt_byte[probe_s2.bit_idx]) begin
			color = oipo_pkg::COLOR_CYAN;
		end else begin
			color = oipo_pkg::COLOR_YELLOW;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			result_q.covered <= is_probe_s2 && probe_s2.covered;
			result_q.color_code <= color;
			result_q.char_dropped <= !is_probe_s2 && dropped_s2;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

[rtl/core/oipo_id_store.sv]
// ID storage: character memory, length, end flag and byte sum.
// Applies load transfers and serves one registered read for the probe path.
// Depends on no other file.
module oipo_id_store #(
	parameter int unsigned MAX_ID_CHARS = 11,
	parameter int unsigned LEN_W = 4,
	parameter int unsigned AW = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [7:0]       id_char,
	input  logic             first_char,
	input  logic [AW-1:0]    rd_addr,
	output logic [LEN_W-1:0] len,
	output logic [7:0]       sum,
	output logic             dropped,
	output logic [7:0]       rd_data_s2
);

	logic [7:0] mem [MAX_ID_CHARS];
	logic [LEN_W-1:0] len_q, len_eff, len_d;
	logic [7:0] sum_q, sum_eff, sum_d;
	logic ended_q, ended_eff, ended_d;
	logic wr_en;

	always_comb begin
		len_eff = first_char ? '0 : len_q;
		sum_eff = first_char ? 8'h00 : sum_q;
		ended_eff = first_char ? 1'b0 : ended_q;
		len_d = len_eff;
		sum_d = sum_eff;
		ended_d = ended_eff;
		dropped = 1'b0;
		wr_en = 1'b0;
		if (ended_eff) begin
			dropped = 1'b1;
		end else if (id_char == 8'h00) begin
			ended_d = 1'b1;
		end else if (len_eff >= LEN_W'(MAX_ID_CHARS)) begin
			dropped = 1'b1;
			ended_d = 1'b1;
		end else begin
			wr_en = 1'b1;
			len_d = LEN_W'(len_eff + LEN_W'(1));
			sum_d = 8'(sum_eff + id_char);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			sum_q <= 8'h00;
			ended_q <= 1'b0;
		end else if (load) begin
			len_q <= len_d;
			sum_q <= sum_d;
			ended_q <= ended_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load && wr_en) begin
			mem[AW'(len_eff)] <= id_char;
		end
		rd_data_s2 <= mem[rd_addr];
	end

	assign len = len_q;
	assign sum = sum_q;

endmodule

[rtl/core/oipo_probe_map.sv]
// Probe geometry: pattern placement, hit test and packet byte selection.
// Combinational; depends on oipo_pkg.
module oipo_probe_map #(
	parameter int unsigned LEN_W = 4,
	parameter int unsigned PL_W = 5,
	parameter int unsigned AW = 4
) (
	input  logic [oipo_pkg::COORD_W-1:0] screen_width,
	input  logic [oipo_pkg::COORD_W-1:0] screen_height,
	input  logic [oipo_pkg::COORD_W-1:0] pixel_x,
	input  logic [oipo_pkg::COORD_W-1:0] pixel_y,
	input  logic [LEN_W-1:0]             len,
	input  logic [7:0]                   sum,
	output oipo_pkg::probe_t             probe,
	output logic [AW-1:0]                rd_addr
);

	localparam int unsigned GW = oipo_pkg::GEO_W;

	logic [PL_W-1:0] plen, n_pl, byte_i;
	logic [PL_W+3:0] span;
	logic signed [GW-1:0] xs, ys, dx, dy;
	logic [7:0] chk_sum, chk;
	logic in_x, in_y;

	always_comb begin
		n_pl = PL_W'(len);
		plen = PL_W'(n_pl + PL_W'(7));
		span = {plen, 4'b0000};
		xs = GW'(screen_width[oipo_pkg::COORD_W-1:1]) - (GW'(plen) << 3);
		ys = GW'(screen_height) - (GW'(screen_height[oipo_pkg::COORD_W-1:3]) << 1)
			- GW'(oipo_pkg::ROW_MARGIN);
		dx = GW'(pixel_x) - xs;
		dy = GW'(pixel_y) - ys;
		in_x = !dx[GW-1] && (dx[GW-2:0] < (GW-1)'(span));
		in_y = (dy == GW'(0)) || (dy == GW'(1));
		byte_i = dx[PL_W+3:4];
		chk_sum = 8'(8'(len) + sum + oipo_pkg::PKT_TAIL);
		chk = 8'(8'h00 - chk_sum);

		probe.covered = (len != '0) && in_x && in_y;
		probe.marker = ~dx[0];
		probe.bit_idx = ~dx[3:1];
		probe.use_mem = 1'b0;
		if (byte_i == PL_W'(0)) begin
			probe.fix_byte = oipo_pkg::PKT_HEAD;
		end else if (byte_i == PL_W'(1)) begin
			probe.fix_byte = 8'h00;
		end else if (byte_i == PL_W'(2)) begin
			probe.fix_byte = chk;
		end else if (byte_i == PL_W'(3)) begin
			probe.fix_byte = 8'(len);
		end else if (byte_i < PL_W'(n_pl + PL_W'(4))) begin
			probe.fix_byte = 8'h00;
			probe.use_mem = 1'b1;
		end else if (byte_i == PL_W'(n_pl + PL_W'(5))) begin
			probe.fix_byte = oipo_pkg::PKT_TAIL;
		end else begin
			probe.fix_byte = 8'h00;
		end
		rd_addr = AW'(byte_i - PL_W'(4));
	end

endmodule
